[rtl/pimc_pkg.sv]
// shared constants and types for the projective inverse coordinate mapper
`timescale 1ns / 1ps
package pimc_pkg;
  localparam int COORD_W = 12;
  localparam int MAX_SRC_DIM = 2048;
  localparam int MAX_OUT_DIM = 4096;
  localparam int OUT_W = 11;
  localparam int COEF_W = 21;
  localparam int ROW_W = 3 * COEF_W;
  localparam int DIM_W = 12;
  localparam int PROD_W = COEF_W + COORD_W + 1;
  localparam int SUM_W = PROD_W + 2;
  localparam int FRAC_SHIFT = 10;
  localparam int NUM_W = SUM_W + FRAC_SHIFT + 1;
  localparam int DEN_W = SUM_W;
  localparam int QBITS = OUT_W;
  localparam int DIV_LAT = QBITS + 1;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic negx;
    logic negy;
    logic wzero;
  } sign_t;
endpackage

[rtl/pimc_in_if.sv]
// input channel carrying one output pixel coordinate word
`timescale 1ns / 1ps
interface pimc_in_if;
  logic valid;
  logic ready;
  logic [pimc_pkg::COORD_W-1:0] out_col;
  logic [pimc_pkg::COORD_W-1:0] out_row;
  modport source (output valid, output out_col, output out_row, input ready);
  modport sink (input valid, input out_col, input out_row, output ready);
endinterface

[rtl/pimc_out_if.sv]
// output channel carrying one mapped source coordinate word
`timescale 1ns / 1ps
interface pimc_out_if;
  logic valid;
  logic ready;
  logic [pimc_pkg::OUT_W-1:0] src_col;
  logic [pimc_pkg::OUT_W-1:0] src_row;
  logic inside_res;
  modport source (output valid, output src_col, output src_row, output inside_res, input ready);
  modport sink (input valid, input src_col, input src_row, input inside_res, output ready);
endinterface

[rtl/pimc_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
module pimc_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pimc_pkg::NUM_W-1:0]   num,
  input  logic [pimc_pkg::DEN_W-1:0]   den,
  output logic [pimc_pkg::QBITS-1:0]   quo,
  output logic                         big
);
  logic [pimc_pkg::NUM_W-1:0] rem [0:pimc_pkg::QBITS];
  logic [pimc_pkg::DEN_W-1:0] dd  [0:pimc_pkg::QBITS];
  logic [pimc_pkg::QBITS-1:0] qq  [0:pimc_pkg::QBITS];
  logic                       bg  [0:pimc_pkg::QBITS];
  logic [pimc_pkg::NUM_W:0]   dtop;

  assign dtop = (pimc_pkg::NUM_W + 1)'(den) << pimc_pkg::QBITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dd[0]  <= den;
      qq[0]  <= '0;
      bg[0]  <= ({1'b0, num} >= dtop);
    end
  end

  for (genvar s = 1; s <= pimc_pkg::QBITS; s++) begin : g_stage
    localparam int K = pimc_pkg::QBITS - s;
    logic [pimc_pkg::NUM_W:0] dsh;
    logic [pimc_pkg::NUM_W:0] diff;
    logic                     ge;
    assign dsh  = (pimc_pkg::NUM_W + 1)'(dd[s-1]) << K;
    assign diff = {1'b0, rem[s-1]} - dsh;
    assign ge   = ~diff[pimc_pkg::NUM_W];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? diff[pimc_pkg::NUM_W-1:0] : rem[s-1];
        dd[s]  <= dd[s-1];
        qq[s]  <= qq[s-1] | (pimc_pkg::QBITS'(ge) << K);
        bg[s]  <= bg[s-1];
      end
    end
  end

  assign quo = qq[pimc_pkg::QBITS];
  assign big = bg[pimc_pkg::QBITS];
endmodule

[rtl/projective_inverse_map_coords.sv]
// top level: coordinate times inverse homography, divide by w, bounds test
`timescale 1ns / 1ps
// pipeline: saturate, multiply, sum, magnitude, 12 divider stages, output
// throughput one word per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// rst clears valid bits and loads the identity matrix with a 640x480 source
module projective_inverse_map_coords (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pimc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pimc_pkg::DATA_W-1:0]   pwdata,
  output logic [pimc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  pimc_in_if.sink                       in_ch,
  pimc_out_if.source                    out_ch
);
  logic [pimc_pkg::ROW_W-1:0] row0, row1, row2;
  logic [pimc_pkg::DIM_W-1:0] src_width, src_height;
  pimc_pkg::reg_idx_t         ridx;
  logic                       en;

  assign pready = 1'b1;
  assign ridx = pimc_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row0       <= pimc_pkg::ROW_W'(256);
      row1       <= pimc_pkg::ROW_W'(1) << 29;
      row2       <= pimc_pkg::ROW_W'(1) << 60;
      src_width  <= pimc_pkg::DIM_W'(640);
      src_height <= pimc_pkg::DIM_W'(480);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        pimc_pkg::REG_ROW0:   row0 <= pwdata[pimc_pkg::ROW_W-1:0];
        pimc_pkg::REG_ROW1:   row1 <= pwdata[pimc_pkg::ROW_W-1:0];
        pimc_pkg::REG_ROW2:   row2 <= pwdata[pimc_pkg::ROW_W-1:0];
        pimc_pkg::REG_WIDTH:  src_width <= pwdata[pimc_pkg::DIM_W-1:0];
        pimc_pkg::REG_HEIGHT: src_height <= pwdata[pimc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      pimc_pkg::REG_ROW0:   prdata = pimc_pkg::DATA_W'(row0);
      pimc_pkg::REG_ROW1:   prdata = pimc_pkg::DATA_W'(row1);
      pimc_pkg::REG_ROW2:   prdata = pimc_pkg::DATA_W'(row2);
      pimc_pkg::REG_WIDTH:  prdata = pimc_pkg::DATA_W'(src_width);
      pimc_pkg::REG_HEIGHT: prdata = pimc_pkg::DATA_W'(src_height);
      default:              prdata = '0;
    endcase
  end

  assign en = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: saturate coordinates
  logic                          v1;
  logic [pimc_pkg::COORD_W-1:0]  c1, r1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= (32'(in_ch.out_col) > pimc_pkg::MAX_OUT_DIM - 1) ?
            pimc_pkg::COORD_W'(pimc_pkg::MAX_OUT_DIM - 1) : in_ch.out_col;
      r1 <= (32'(in_ch.out_row) > pimc_pkg::MAX_OUT_DIM - 1) ?
            pimc_pkg::COORD_W'(pimc_pkg::MAX_OUT_DIM - 1) : in_ch.out_row;
    end
  end

  // stage 2: products
  logic v2;
  logic signed [pimc_pkg::PROD_W-1:0] pxc, pxr, pyc, pyr, pwc, pwr;
  logic signed [pimc_pkg::COEF_W-1:0] kx, ky, kw;
  logic signed [pimc_pkg::COORD_W:0]  cs, rs;
  assign cs = $signed({1'b0, c1});
  assign rs = $signed({1'b0, r1});
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pxc <= $signed(row0[20:0]) * cs;
      pxr <= $signed(row0[41:21]) * rs;
      pyc <= $signed(row1[20:0]) * cs;
      pyr <= $signed(row1[41:21]) * rs;
      pwc <= $signed(row2[20:0]) * cs;
      pwr <= $signed(row2[41:21]) * rs;
      kx  <= $signed(row0[62:42]);
      ky  <= $signed(row1[62:42]);
      kw  <= $signed(row2[62:42]);
    end
  end

  // stage 3: dot products
  logic v3;
  logic signed [pimc_pkg::SUM_W-1:0] xs, ys, ws;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      xs <= pimc_pkg::SUM_W'(pxc) + pimc_pkg::SUM_W'(pxr) + pimc_pkg::SUM_W'(kx);
      ys <= pimc_pkg::SUM_W'(pyc) + pimc_pkg::SUM_W'(pyr) + pimc_pkg::SUM_W'(ky);
      ws <= pimc_pkg::SUM_W'(pwc) + pimc_pkg::SUM_W'(pwr) + pimc_pkg::SUM_W'(kw);
    end
  end

  // stage 4: magnitudes and signs
  logic v4;
  logic [pimc_pkg::NUM_W-1:0] nx, ny;
  logic [pimc_pkg::DEN_W-1:0] dw;
  pimc_pkg::sign_t            sg4;
  logic [pimc_pkg::SUM_W-1:0] ax, ay;
  assign ax = xs[pimc_pkg::SUM_W-1] ? pimc_pkg::SUM_W'(-xs) : pimc_pkg::SUM_W'(xs);
  assign ay = ys[pimc_pkg::SUM_W-1] ? pimc_pkg::SUM_W'(-ys) : pimc_pkg::SUM_W'(ys);
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx <= pimc_pkg::NUM_W'(ax) << pimc_pkg::FRAC_SHIFT;
      ny <= pimc_pkg::NUM_W'(ay) << pimc_pkg::FRAC_SHIFT;
      dw <= ws[pimc_pkg::SUM_W-1] ? pimc_pkg::DEN_W'(-ws) : pimc_pkg::DEN_W'(ws);
      sg4.negx  <= xs[pimc_pkg::SUM_W-1] ^ ws[pimc_pkg::SUM_W-1];
      sg4.negy  <= ys[pimc_pkg::SUM_W-1] ^ ws[pimc_pkg::SUM_W-1];
      sg4.wzero <= (ws == '0);
    end
  end

  // dividers with side pipes for valid and signs
  logic [pimc_pkg::QBITS-1:0] qx, qy;
  logic                       bigx, bigy;
  pimc_div u_divx (.clk(clk), .en(en), .num(nx), .den(dw), .quo(qx), .big(bigx));
  pimc_div u_divy (.clk(clk), .en(en), .num(ny), .den(dw), .quo(qy), .big(bigy));

  logic            vd [0:pimc_pkg::DIV_LAT-1];
  pimc_pkg::sign_t sd [0:pimc_pkg::DIV_LAT-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pimc_pkg::DIV_LAT; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v4;
      for (int i = 1; i < pimc_pkg::DIV_LAT; i++) vd[i] <= vd[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= sg4;
      for (int i = 1; i < pimc_pkg::DIV_LAT; i++) sd[i] <= sd[i-1];
    end
  end

  // output stage: bounds test
  pimc_pkg::sign_t            sgo;
  logic [pimc_pkg::DIM_W-1:0] wd, hd;
  logic                       okx, oky, in_src;
  assign sgo = sd[pimc_pkg::DIV_LAT-1];
  assign wd = (32'(src_width) > pimc_pkg::MAX_SRC_DIM) ?
              pimc_pkg::DIM_W'(pimc_pkg::MAX_SRC_DIM) : src_width;
  assign hd = (32'(src_height) > pimc_pkg::MAX_SRC_DIM) ?
              pimc_pkg::DIM_W'(pimc_pkg::MAX_SRC_DIM) : src_height;
  assign okx = ~bigx && (qx == '0 || ~sgo.negx) && (pimc_pkg::DIM_W'(qx) < wd);
  assign oky = ~bigy && (qy == '0 || ~sgo.negy) && (pimc_pkg::DIM_W'(qy) < hd);
  assign in_src = okx && oky && ~sgo.wzero;

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= vd[pimc_pkg::DIV_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.src_col    <= in_src ? qx : '0;
      out_ch.src_row    <= in_src ? qy : '0;
      out_ch.inside_res <= in_src;
    end
  end
endmodule

[tb/tb_projective_inverse_map_coords.sv]
// testbench for the projective inverse coordinate mapper: predicted words checked in order
`timescale 1ns / 1ps
module tb_projective_inverse_map_coords;

  typedef struct packed {
    logic [pimc_pkg::OUT_W-1:0] col;
    logic [pimc_pkg::OUT_W-1:0] row;
    logic                       hit;
  } src_word_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pimc_pkg::ADDR_W-1:0] paddr = '0;
  logic [pimc_pkg::DATA_W-1:0] pwdata = '0;
  logic [pimc_pkg::DATA_W-1:0] prdata;
  logic pready;

  pimc_in_if in_ch ();
  pimc_out_if out_ch ();

  projective_inverse_map_coords dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  logic [pimc_pkg::ROW_W-1:0] mat_row [3];
  logic [pimc_pkg::DIM_W-1:0] width_q, height_q;
  src_word_t mapped_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit sink_random = 1'b1;
  int hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.out_col = '0;
    in_ch.out_row = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint coef_of(logic [pimc_pkg::ROW_W-1:0] row, int k);
    logic signed [pimc_pkg::COEF_W-1:0] c;
    c = row[k*pimc_pkg::COEF_W +: pimc_pkg::COEF_W];
    return longint'(c);
  endfunction

  function automatic src_word_t map_coord(logic [pimc_pkg::COORD_W-1:0] ci,
                                          logic [pimc_pkg::COORD_W-1:0] ri);
    longint c, r, x, y, w, u, v, wd, hd;
    src_word_t res;
    c = ci;
    r = ri;
    x = coef_of(mat_row[0], 0) * c + coef_of(mat_row[0], 1) * r + coef_of(mat_row[0], 2);
    y = coef_of(mat_row[1], 0) * c + coef_of(mat_row[1], 1) * r + coef_of(mat_row[1], 2);
    w = coef_of(mat_row[2], 0) * c + coef_of(mat_row[2], 1) * r + coef_of(mat_row[2], 2);
    wd = (width_q > pimc_pkg::MAX_SRC_DIM) ? pimc_pkg::MAX_SRC_DIM : width_q;
    hd = (height_q > pimc_pkg::MAX_SRC_DIM) ? pimc_pkg::MAX_SRC_DIM : height_q;
    res = '0;
    if (w != 0) begin
      u = (x * 1024) / w;
      v = (y * 1024) / w;
      if (u >= 0 && u < wd && v >= 0 && v < hd) begin
        res.col = u[pimc_pkg::OUT_W-1:0];
        res.row = v[pimc_pkg::OUT_W-1:0];
        res.hit = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic write_reg(pimc_pkg::reg_idx_t idx, logic [pimc_pkg::DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pimc_pkg::ADDR_W'(8 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pimc_pkg::REG_ROW0: mat_row[0] = val[pimc_pkg::ROW_W-1:0];
      pimc_pkg::REG_ROW1: mat_row[1] = val[pimc_pkg::ROW_W-1:0];
      pimc_pkg::REG_ROW2: mat_row[2] = val[pimc_pkg::ROW_W-1:0];
      pimc_pkg::REG_WIDTH: width_q = val[pimc_pkg::DIM_W-1:0];
      pimc_pkg::REG_HEIGHT: height_q = val[pimc_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic read_reg(pimc_pkg::reg_idx_t idx, logic [pimc_pkg::DATA_W-1:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= pimc_pkg::ADDR_W'(8 * idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report("prdata", int'(prdata[31:0]), int'(want[31:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_coord(logic [pimc_pkg::COORD_W-1:0] c,
                            logic [pimc_pkg::COORD_W-1:0] r, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.out_col <= c;
    in_ch.out_row <= r;
    do @(posedge clk); while (!in_ch.ready);
    mapped_q.push_back(map_coord(c, r));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (mapped_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        src_word_t e;
        e = mapped_q.pop_front();
        if (out_ch.src_col !== e.col) report("src_col", out_ch.src_col, e.col);
        if (out_ch.src_row !== e.row) report("src_row", out_ch.src_row, e.row);
        if (out_ch.inside_res !== e.hit) report("inside_res", out_ch.inside_res, e.hit);
      end
    end
  end

  // sink stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (!sink_random) begin
      out_ch.ready <= 1'b1;
    end else if (!out_ch.ready || out_ch.valid) begin
      if ($urandom_range(0, 3) == 0) hold_cycles <= $urandom_range(0, 14);
      else out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [pimc_pkg::DATA_W-1:0] pack_row(int a, int b, int c);
    return {1'b0, pimc_pkg::COEF_W'(c), pimc_pkg::COEF_W'(b), pimc_pkg::COEF_W'(a)};
  endfunction

  task automatic test_readback();
    read_reg(pimc_pkg::REG_ROW0, pimc_pkg::DATA_W'(mat_row[0]));
    read_reg(pimc_pkg::REG_ROW1, pimc_pkg::DATA_W'(mat_row[1]));
    read_reg(pimc_pkg::REG_ROW2, pimc_pkg::DATA_W'(mat_row[2]));
    read_reg(pimc_pkg::REG_WIDTH, pimc_pkg::DATA_W'(width_q));
    read_reg(pimc_pkg::REG_HEIGHT, pimc_pkg::DATA_W'(height_q));
  endtask

  task automatic test_reset_identity();
    send_coord(0, 0, 0);
    send_coord(639, 479, 0);
    send_coord(640, 0, 0);
    send_coord(0, 480, 0);
    send_coord(4095, 4095, 0);
    send_coord(12'hAAA, 12'h555, 1);
    send_coord(12'h555, 12'hAAA, 1);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(pimc_pkg::REG_WIDTH, 2048);
    write_reg(pimc_pkg::REG_HEIGHT, 4095);
    send_coord(2047, 2047, 0);
    send_coord(2048, 100, 0);
    drain();
    write_reg(pimc_pkg::REG_WIDTH, 0);
    send_coord(0, 0, 0);
    drain();
    write_reg(pimc_pkg::REG_WIDTH, 1);
    write_reg(pimc_pkg::REG_HEIGHT, 1);
    send_coord(0, 0, 0);
    send_coord(1, 0, 0);
    drain();
    write_reg(pimc_pkg::REG_ROW2, 0);
    send_coord(5, 5, 0);
    drain();
    write_reg(pimc_pkg::REG_ROW0, pack_row(-256, 0, 0));
    write_reg(pimc_pkg::REG_ROW1, pack_row(0, -256, 0));
    write_reg(pimc_pkg::REG_ROW2, pack_row(0, 0, 1 << 18));
    write_reg(pimc_pkg::REG_WIDTH, 2048);
    write_reg(pimc_pkg::REG_HEIGHT, 2048);
    send_coord(3, 3, 0);
    send_coord(0, 0, 0);
    drain();
    write_reg(pimc_pkg::REG_ROW0, pack_row(-(1 << 20), (1 << 20) - 1, (1 << 20) - 1));
    write_reg(pimc_pkg::REG_ROW1, pack_row((1 << 20) - 1, -(1 << 20), -(1 << 20)));
    write_reg(pimc_pkg::REG_ROW2, pack_row(-(1 << 20), (1 << 20) - 1, 1));
    send_coord(4095, 0, 0);
    send_coord(0, 4095, 0);
    send_coord(1, 1, 0);
    drain();
  endtask

  task automatic random_matrix();
    write_reg(pimc_pkg::REG_ROW0,
              pack_row($urandom_range(0, 512) - 256, $urandom_range(0, 128) - 64,
                       $urandom_range(0, 200000) - 100000));
    write_reg(pimc_pkg::REG_ROW1,
              pack_row($urandom_range(0, 128) - 64, $urandom_range(0, 512) - 256,
                       $urandom_range(0, 200000) - 100000));
    write_reg(pimc_pkg::REG_ROW2,
              pack_row($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                       $urandom_range(1 << 17, 1 << 19)));
    write_reg(pimc_pkg::REG_WIDTH, $urandom_range(1, 2100));
    write_reg(pimc_pkg::REG_HEIGHT, $urandom_range(1, 2100));
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        write_reg(pimc_pkg::REG_ROW0, {1'b0, 63'($urandom()) << 32 | 63'($urandom())});
        write_reg(pimc_pkg::REG_ROW1, {1'b0, 63'($urandom()) << 32 | 63'($urandom())});
        write_reg(pimc_pkg::REG_ROW2, {1'b0, 63'($urandom()) << 32 | 63'($urandom())});
      end else begin
        random_matrix();
      end
      sink_random = (p % 2 == 0);
      for (int i = 0; i < 100; i++)
        send_coord($urandom_range(0, 2600), $urandom_range(0, 2600), (p % 3) != 1);
      drain();
    end
    sink_random = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 60; i++)
      send_coord($urandom_range(0, 4095), $urandom_range(0, 4095), 0);
    drain();
  endtask

  initial begin
    mat_row[0] = 256;
    mat_row[1] = 1 << 29;
    mat_row[2] = 63'(1) << 60;
    width_q = 640;
    height_q = 480;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_readback();
    test_reset_identity();
    test_extremes();
    test_random();
    test_backpressure();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
